// File: src/iodp_pkg.sv
// Package for the io device pool dispatcher: sizes, event and result codes.
// No dependencies.
`default_nettype none
package iodp_pkg;
   localparam int NUM_CLASSES = 8;
   localparam int NUM_DEVICES = 16;
   localparam int WAIT_DEPTH  = 16;
   localparam int CW = $clog2(NUM_CLASSES);
   localparam int DW = $clog2(NUM_DEVICES);
   localparam int QW = $clog2(WAIT_DEPTH);
   localparam int NW = $clog2(WAIT_DEPTH + 1);
   localparam int KW = $clog2(NUM_DEVICES + 1);

   typedef enum logic [1:0] {
      OP_CONNECT = 2'd0, OP_REQUEST = 2'd1, OP_FINISH = 2'd2, OP_DISCONNECT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DISPATCH = 2'd0, KIND_READY = 2'd1, KIND_KILLED = 2'd2, KIND_REJECT = 2'd3
   } kind_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture input word
      logic decide;    // update state, set first result, start dispatch read
      logic pick;      // run dispatch, set second result
      logic take2;     // hand out second result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic has1;      // first result exists
      logic has2;      // dispatch happened
      logic try_disp;  // a dispatch attempt follows
   } sts_type;
endpackage
`default_nettype wire

// File: src/iodp_datapath.sv
// Datapath: device table, class counts, wait FIFOs and result registers.
// Depends on iodp_pkg.
`default_nettype none
module iodp_datapath import iodp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output sts_type            sts,
   input  wire logic [1:0]    req_op,
   input  wire logic [2:0]    req_class_id,
   input  wire logic [3:0]    req_device_id,
   input  wire logic [15:0]   req_job_pid,
   input  wire logic [31:0]   req_duration,
   output logic [1:0]         rsp_kind,
   output logic [3:0]         rsp_out_device,
   output logic [15:0]        rsp_out_pid,
   output logic [31:0]        rsp_out_duration
);
   logic [1:0]  op_ff;
   logic [2:0]  cls_ff;
   logic [3:0]  dev_ff;
   logic [15:0] pid_ff;
   logic [31:0] dur_ff;

   logic [NUM_DEVICES-1:0] present_ff, busy_ff;
   logic [CW-1:0] dclass_ff [NUM_DEVICES];
   logic [15:0]   rpid_ff   [NUM_DEVICES];
   logic [KW-1:0] count_ff  [NUM_CLASSES];
   logic [QW-1:0] head_ff   [NUM_CLASSES];
   logic [NW-1:0] fill_ff   [NUM_CLASSES];
   logic [47:0]   wmem [NUM_CLASSES*WAIT_DEPTH];
   logic [47:0]   rd_ff;

   logic [1:0]  k1_ff;
   logic [15:0] p1_ff;
   logic [3:0]  d2_ff;
   logic [15:0] p2_ff;
   logic [31:0] t2_ff;
   logic        has1_ff, has2_ff, try_ff;
   logic [CW-1:0] dc_ff;   // class to dispatch

   // decoded input
   logic dev_ok, cls_ok;
   logic [DW-1:0] di;
   logic [CW-1:0] ci, dcls;
   assign dev_ok = {28'd0, dev_ff} < 32'(NUM_DEVICES);
   assign cls_ok = {29'd0, cls_ff} < 32'(NUM_CLASSES);
   assign di   = dev_ff[DW-1:0];
   assign ci   = cls_ff[CW-1:0];
   assign dcls = dclass_ff[di];

   // lowest idle device of the dispatch class
   logic          found;
   logic [DW-1:0] fdev;
   always_comb begin
      found = 1'b0;
      fdev  = '0;
      for (int i = NUM_DEVICES - 1; i >= 0; i--) begin
         if (present_ff[i] && !busy_ff[i] && dclass_ff[i] == dc_ff) begin
            found = 1'b1;
            fdev  = DW'(i);
         end
      end
   end

   logic [QW-1:0] slot;
   assign slot = QW'(head_ff[ci] + QW'(fill_ff[ci]));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op; cls_ff <= req_class_id; dev_ff <= req_device_id;
         pid_ff <= req_job_pid; dur_ff <= req_duration;
      end
      if (cmd.decide && op_type'(op_ff) == OP_REQUEST && cls_ok && count_ff[ci] != '0
          && fill_ff[ci] != NW'(WAIT_DEPTH))
         wmem[{ci, slot}] <= {pid_ff, dur_ff};
      rd_ff <= wmem[{dc_ff, head_ff[dc_ff]}];
      if (cmd.decide) begin
         case (op_type'(op_ff))
            OP_REQUEST: begin
               k1_ff <= (cls_ok && count_ff[ci] != '0) ? KIND_REJECT : KIND_KILLED;
               p1_ff <= pid_ff;
            end
            OP_FINISH: begin
               k1_ff <= KIND_READY; p1_ff <= rpid_ff[di];
            end
            OP_DISCONNECT: begin
               k1_ff <= KIND_KILLED; p1_ff <= rpid_ff[di];
            end
            default: begin
               k1_ff <= KIND_KILLED; p1_ff <= pid_ff;
            end
         endcase
      end
      if (cmd.pick) begin
         d2_ff <= 4'(fdev); p2_ff <= rd_ff[47:32]; t2_ff <= rd_ff[31:0];
      end
   end

   // control state of the tables
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0; busy_ff <= '0;
         has1_ff <= 1'b0; has2_ff <= 1'b0; try_ff <= 1'b0; dc_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            count_ff[i] <= '0; head_ff[i] <= '0; fill_ff[i] <= '0;
         end
      end else begin
         if (cmd.decide) begin
            has2_ff <= 1'b0;
            case (op_type'(op_ff))
               OP_CONNECT: begin
                  has1_ff <= 1'b0; try_ff <= 1'b0;
                  if (dev_ok && cls_ok && !present_ff[di]) begin
                     present_ff[di] <= 1'b1; busy_ff[di] <= 1'b0;
                     dclass_ff[di] <= ci; count_ff[ci] <= count_ff[ci] + 1'b1;
                  end
               end
               OP_REQUEST:
                  if (!cls_ok || count_ff[ci] == '0 || fill_ff[ci] == NW'(WAIT_DEPTH)) begin
                     has1_ff <= 1'b1; try_ff <= 1'b0;
                  end else begin
                     has1_ff <= 1'b0;
                     fill_ff[ci] <= fill_ff[ci] + 1'b1;
                     try_ff <= 1'b1; dc_ff <= ci;
                  end
               OP_FINISH:
                  if (dev_ok && present_ff[di] && busy_ff[di]) begin
                     busy_ff[di] <= 1'b0; has1_ff <= 1'b1;
                     try_ff <= 1'b1; dc_ff <= dcls;
                  end else begin
                     has1_ff <= 1'b0; try_ff <= 1'b0;
                  end
               OP_DISCONNECT: begin
                  try_ff <= 1'b0;
                  if (dev_ok && present_ff[di]) begin
                     has1_ff <= busy_ff[di];
                     present_ff[di] <= 1'b0; busy_ff[di] <= 1'b0;
                     if (count_ff[dcls] <= KW'(1)) begin
                        count_ff[dcls] <= '0; head_ff[dcls] <= '0; fill_ff[dcls] <= '0;
                     end else
                        count_ff[dcls] <= count_ff[dcls] - 1'b1;
                  end else
                     has1_ff <= 1'b0;
               end
               default: begin
                  has1_ff <= 1'b0; try_ff <= 1'b0;
               end
            endcase
         end
         if (cmd.pick && fill_ff[dc_ff] != '0 && found) begin
            has2_ff <= 1'b1; busy_ff[fdev] <= 1'b1; rpid_ff[fdev] <= rd_ff[47:32];
            head_ff[dc_ff] <= head_ff[dc_ff] + 1'b1;
            fill_ff[dc_ff] <= fill_ff[dc_ff] - 1'b1;
         end
      end
   end

   assign sts = '{has1: has1_ff, has2: has2_ff, try_disp: try_ff};

   // result mux: second result only after first is taken
   always_comb begin
      if (cmd.take2) begin
         rsp_kind = KIND_DISPATCH; rsp_out_device = d2_ff;
         rsp_out_pid = p2_ff; rsp_out_duration = t2_ff;
      end else begin
         rsp_kind = k1_ff; rsp_out_device = '0;
         rsp_out_pid = p1_ff; rsp_out_duration = '0;
      end
   end

   // a pick with an idle device and a queued job dispatches
   assert property (@(posedge clock) disable iff (reset)
      cmd.pick && found && fill_ff[dc_ff] != '0 |=> has2_ff) else $error("no dispatch");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff & ~present_ff) == '0) else $error("busy absent device");
   assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= NW'(WAIT_DEPTH)) else $error("fifo overfill");
endmodule
`default_nettype wire

// File: src/iodp_ctrl.sv
// Controller: sequences load, decide, dispatch and result handoff.
// Depends on iodp_pkg.
`default_nettype none
module iodp_ctrl import iodp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic         rsp_last,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DEC = 6'b000010, S_RD = 6'b000100,
      S_PICK = 6'b001000, S_OUT1 = 6'b010000, S_OUT2 = 6'b100000
   } state_type;
   state_type state_ff, state_in;

   // first result only shows when it exists
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = (state_ff == S_OUT1 && sts.has1) || state_ff == S_OUT2;
   assign rsp_last  = state_ff == S_OUT2 || !sts.has2;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) begin cmd.load = 1'b1; state_in = S_DEC; end
         S_DEC: begin cmd.decide = 1'b1; state_in = S_RD; end
         S_RD: state_in = sts.try_disp ? S_PICK : (sts.has1 ? S_OUT1 : S_IDLE);
         S_PICK: begin
            cmd.pick = 1'b1; state_in = S_OUT1;
         end
         S_OUT1: begin
            if (!sts.has1) state_in = sts.has2 ? S_OUT2 : S_IDLE;
            else if (rsp_ready) state_in = sts.has2 ? S_OUT2 : S_IDLE;
         end
         S_OUT2: begin
            cmd.take2 = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not onehot");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DEC) else $error("no decide");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEC |=> state_ff == S_RD) else $error("bad sequence");
endmodule
`default_nettype wire

// File: src/io_device_pool_dispatcher.sv
// io device pool dispatcher top level: controller plus datapath.
// Each word goes through load, decide and read; a finish or a queued request adds
// a pick step before the results. Later results one per cycle as taken; the next
// word is accepted only once all results of the last word are out.
// Reset: synchronous, clears device flags, class counts and queue pointers.
`default_nettype none
module io_device_pool_dispatcher import iodp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [2:0]  req_class_id,
   input  wire logic [3:0]  req_device_id,
   input  wire logic [15:0] req_job_pid,
   input  wire logic [31:0] req_duration,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [3:0]       rsp_out_device,
   output logic [15:0]      rsp_out_pid,
   output logic [31:0]      rsp_out_duration,
   output logic             rsp_last
);
   cmd_type cmd;
   sts_type sts;

   iodp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_last, .cmd, .sts
   );

   iodp_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_op, .req_class_id, .req_device_id,
      .req_job_pid, .req_duration, .rsp_kind, .rsp_out_device,
      .rsp_out_pid, .rsp_out_duration
   );
endmodule
`default_nettype wire
